FILE: design/dpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Register indexes, reset values, field widths, queue depths and the
// configuration and result records passed between the blocks.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_FRAME_DIM_DEF = 4096;
  localparam int unsigned RECIP_FRAC_DEF    = 24;

  // Field widths
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned CENTER_W = 16;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned XY_W     = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Saturation limits of the 23-bit signed coordinates
  localparam longint unsigned XY_MAX_POS = 64'd4194303;
  localparam longint unsigned XY_MAX_NEG = 64'd4194304;

  // Queue depths
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
  localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_X  = 24'd27962;
  localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_Y  = 24'd27962;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [CENTER_W-1:0] center_x_q4;
    logic [CENTER_W-1:0] center_y_q4;
    logic [RECIP_W-1:0]  inv_focal_x_q24;
    logic [RECIP_W-1:0]  inv_focal_y_q24;
  } cfg_t;

  typedef struct packed {
    logic [XY_W-1:0]    point_x_q4;
    logic [XY_W-1:0]    point_y_q4;
    logic [DEPTH_W-1:0] point_z_mm;
    logic               point_valid;
    logic               frame_end;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: design/dpb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_fifo: small synchronous queue
// Register-based storage with read and write pointers and an occupancy count.
// The head entry is shown on rdata_o while empty_o is low.
// ----------------------------------------------------------------------------
module dpb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the last entry
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the written item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/dpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_front: pixel position tracking and classification
// Keeps the column and row counters, places each accepted pixel, flags the
// last pixel of the frame and forwards only items that yield a result.
// ----------------------------------------------------------------------------
module dpb_front #(
  parameter int unsigned MaxFrameDim = dpb_pkg::MAX_FRAME_DIM_DEF,
  localparam int unsigned CntW  = $clog2(MaxFrameDim),
  localparam int unsigned ItemW = dpb_pkg::DEPTH_W + 2 * CntW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpb_pkg::cfg_t                cfg_i,
  input  logic                         push_i,
  input  logic [dpb_pkg::DEPTH_W-1:0]  depth_mm_i,
  input  logic                         frame_start_i,
  output logic                         full_o,
  input  logic                         mid_full_i,
  output logic                         mid_push_o,
  output logic [ItemW-1:0]             mid_data_o
);
  import dpb_pkg::*;

  localparam int unsigned DimW = (CntW + 1 > DIM_W) ? CntW + 1 : DIM_W;

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic [CntW-1:0] u, v;
  logic [CntW-1:0] last_col, last_row;
  logic            row_end, last_pix, accept;

  // Clamp a configured dimension into [1, MaxFrameDim] and return its last index
  function automatic logic [CntW-1:0] last_index(input logic [DIM_W-1:0] dim);
    logic [DimW-1:0] ext;
    ext = DimW'(dim);
    if (ext == '0) begin
      return '0;
    end else if (ext > DimW'(MaxFrameDim)) begin
      return CntW'(MaxFrameDim - 1);
    end else begin
      return CntW'(ext - DimW'(1));
    end
  endfunction

  assign last_col = last_index(cfg_i.frame_width);
  assign last_row = last_index(cfg_i.frame_height);

  // Place the pixel; a frame start restarts at the origin
  assign u        = frame_start_i ? '0 : col_q;
  assign v        = frame_start_i ? '0 : row_q;
  assign row_end  = (u >= last_col);
  assign last_pix = row_end && (v >= last_row);

  assign full_o     = mid_full_i;
  assign accept     = push_i && !mid_full_i;
  assign mid_push_o = accept && ((depth_mm_i != '0) || last_pix);
  assign mid_data_o = {depth_mm_i, u, v, last_pix};

  // Advance the counters, wrapping at row end and frame end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      priority if (last_pix) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = v + CntW'(1);
      end else begin
        col_d = u + CntW'(1);
        row_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: design/dpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_back: projection pipeline and result queue
// Three register stages compute depth * offset * reciprocal for x and y,
// then round, saturate and write the result queue. Items are drawn from the
// middle queue only while the result queue has room for all in flight.
// ----------------------------------------------------------------------------
module dpb_back #(
  parameter int unsigned MaxFrameDim = dpb_pkg::MAX_FRAME_DIM_DEF,
  parameter int unsigned RecipFrac   = dpb_pkg::RECIP_FRAC_DEF,
  localparam int unsigned CntW  = $clog2(MaxFrameDim),
  localparam int unsigned ItemW = dpb_pkg::DEPTH_W + 2 * CntW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpb_pkg::cfg_t        cfg_i,
  input  logic                 mid_empty_i,
  input  logic [ItemW-1:0]     mid_data_i,
  output logic                 mid_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output dpb_pkg::result_t     result_o
);
  import dpb_pkg::*;

  // Offset magnitude, depth product, split halves and full product widths
  localparam int unsigned MagW   = (CntW + 4 > CENTER_W) ? CntW + 4 : CENTER_W;
  localparam int unsigned MdW    = MagW + DEPTH_W;
  localparam int unsigned LoW    = MdW / 2;
  localparam int unsigned HiW    = MdW - LoW;
  localparam int unsigned ProdW  = MdW + RECIP_W;
  localparam int unsigned QW     = ProdW - RecipFrac;
  localparam int unsigned OCntW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CreditW = OCntW + 1;

  // Unpacked middle-queue item
  logic [DEPTH_W-1:0] in_depth;
  logic [CntW-1:0]    in_u, in_v;
  logic               in_last;

  // Stage 1: offsets
  logic               s1_vld_q;
  logic               s1_negx_q, s1_negy_q;
  logic [MagW-1:0]    s1_magx_q, s1_magy_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic               s1_last_q;
  logic               negx_d, negy_d;
  logic [MagW-1:0]    magx_d, magy_d;

  // Stage 2: magnitude times depth
  logic               s2_vld_q;
  logic               s2_negx_q, s2_negy_q;
  logic [MdW-1:0]     s2_mdx_q, s2_mdy_q;
  logic [DEPTH_W-1:0] s2_depth_q;
  logic               s2_last_q;

  // Stage 3: partial products with the reciprocal
  logic                    s3_vld_q;
  logic                    s3_negx_q, s3_negy_q;
  logic [HiW+RECIP_W-1:0]  s3_phx_q, s3_phy_q;
  logic [LoW+RECIP_W-1:0]  s3_plx_q, s3_ply_q;
  logic [DEPTH_W-1:0]      s3_depth_q;
  logic                    s3_last_q;

  logic               out_full;
  logic [OCntW-1:0]   out_cnt;
  logic [CreditW-1:0] in_flight;
  logic               issue;
  result_t            res_d;
  logic [RESULT_W-1:0] res_rdata;

  assign {in_depth, in_u, in_v, in_last} = mid_data_i;

  // Signed offset of a position from the center, as sign and magnitude
  function automatic logic [MagW:0] offset(input logic [CntW-1:0] pos,
                                           input logic [CENTER_W-1:0] center);
    logic [MagW:0] diff;
    diff = (MagW'(pos) << 4) - (MagW + 1)'(center);
    if (diff[MagW]) begin
      return {1'b1, MagW'(-diff)};
    end else begin
      return {1'b0, diff[MagW-1:0]};
    end
  endfunction

  // Sum partials, round half away from zero on the magnitude, saturate, sign
  function automatic logic [XY_W-1:0] finish(input logic [HiW+RECIP_W-1:0] ph,
                                             input logic [LoW+RECIP_W-1:0] pl,
                                             input logic neg);
    logic [ProdW-1:0] sum;
    logic [QW-1:0]    q;
    sum = (ProdW'(ph) << LoW) + ProdW'(pl) + (ProdW'(1) << (RecipFrac - 1));
    q   = sum[ProdW-1:RecipFrac];
    if (neg) begin
      if (q > QW'(XY_MAX_NEG)) begin
        q = QW'(XY_MAX_NEG);
      end
      return XY_W'(-q);
    end else begin
      if (q > QW'(XY_MAX_POS)) begin
        q = QW'(XY_MAX_POS);
      end
      return q[XY_W-1:0];
    end
  endfunction

  // Issue only while the result queue can absorb every item in flight
  assign in_flight = CreditW'(s1_vld_q) + CreditW'(s2_vld_q) + CreditW'(s3_vld_q)
                   + CreditW'(out_cnt);
  assign issue     = !mid_empty_i && (in_flight < CreditW'(OUT_DEPTH));
  assign mid_pop_o = issue;

  assign {negx_d, magx_d} = offset(in_u, cfg_i.center_x_q4);
  assign {negy_d, magy_d} = offset(in_v, cfg_i.center_y_q4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Move the payload down the stages
  always_ff @(posedge clk_i) begin
    s1_negx_q  <= negx_d;
    s1_negy_q  <= negy_d;
    s1_magx_q  <= magx_d;
    s1_magy_q  <= magy_d;
    s1_depth_q <= in_depth;
    s1_last_q  <= in_last;

    s2_negx_q  <= s1_negx_q;
    s2_negy_q  <= s1_negy_q;
    s2_mdx_q   <= MdW'(s1_magx_q) * MdW'(s1_depth_q);
    s2_mdy_q   <= MdW'(s1_magy_q) * MdW'(s1_depth_q);
    s2_depth_q <= s1_depth_q;
    s2_last_q  <= s1_last_q;

    s3_negx_q  <= s2_negx_q;
    s3_negy_q  <= s2_negy_q;
    s3_phx_q   <= (HiW + RECIP_W)'(s2_mdx_q[MdW-1:LoW])
                * (HiW + RECIP_W)'(cfg_i.inv_focal_x_q24);
    s3_plx_q   <= (LoW + RECIP_W)'(s2_mdx_q[LoW-1:0])
                * (LoW + RECIP_W)'(cfg_i.inv_focal_x_q24);
    s3_phy_q   <= (HiW + RECIP_W)'(s2_mdy_q[MdW-1:LoW])
                * (HiW + RECIP_W)'(cfg_i.inv_focal_y_q24);
    s3_ply_q   <= (LoW + RECIP_W)'(s2_mdy_q[LoW-1:0])
                * (LoW + RECIP_W)'(cfg_i.inv_focal_y_q24);
    s3_depth_q <= s2_depth_q;
    s3_last_q  <= s2_last_q;
  end

  // Build the result; a zero depth gives zero coordinates on its own
  always_comb begin
    res_d.point_x_q4  = finish(s3_phx_q, s3_plx_q, s3_negx_q);
    res_d.point_y_q4  = finish(s3_phy_q, s3_ply_q, s3_negy_q);
    res_d.point_z_mm  = s3_depth_q;
    res_d.point_valid = (s3_depth_q != '0);
    res_d.frame_end   = s3_last_q;
  end

  dpb_fifo #(
    .Width (RESULT_W),
    .Depth (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_vld_q),
    .wdata_i (res_d),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign result_o = result_t'(res_rdata);

  // Result queue never overflows thanks to the issue credit
  always_ff @(posedge clk_i) begin
    if (rst_ni && s3_vld_q && out_full && !pop_i) begin
      $error("dpb_back: result queue overflow");
    end
  end

endmodule

FILE: design/depth_pixel_backprojection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top: pinhole depth-to-point back-projection
// Depth pixels in raster order become x/y/z points in millimetres.
// ----------------------------------------------------------------------------
// Usage: push one depth pixel per cycle while full is low; results appear in
// order at the result queue (empty/pop). An accepted pixel passes through the
// 4-entry middle queue, then the three register stages of the back end (offset,
// depth product, reciprocal partial products), the last of which writes the
// 8-entry result queue. The sustained rate is one pixel per cycle while results
// are popped, set by the single issue slot of that pipeline; the back end issues
// only while the result queue can take every item in flight, so a stalled
// receiver fills both queues and raises full. Zero-depth pixels other than the
// last of a frame are dropped in the front end and never reach the middle queue.
// Write configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top #(
  parameter int unsigned MaxFrameDim = dpb_pkg::MAX_FRAME_DIM_DEF,
  parameter int unsigned RecipFrac   = dpb_pkg::RECIP_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            push,
  output logic                            full,
  input  logic [dpb_pkg::DEPTH_W-1:0]     depth_mm_i,
  input  logic                            frame_start_i,
  // result output
  output logic                            empty,
  input  logic                            pop,
  output logic [dpb_pkg::XY_W-1:0]        point_x_q4_o,
  output logic [dpb_pkg::XY_W-1:0]        point_y_q4_o,
  output logic [dpb_pkg::DEPTH_W-1:0]     point_z_mm_o,
  output logic                            point_valid_o,
  output logic                            frame_end_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dpb_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxFrameDim);
  localparam int unsigned ItemW = DEPTH_W + 2 * CntW + 1;

  cfg_t             cfg_q, cfg_d;
  logic             cfg_we;
  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [ItemW-1:0] mid_wdata, mid_rdata;
  result_t          result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_d.frame_width     = cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height    = cfg_data_i[DIM_W-1:0];
        REG_CENTER_X:     cfg_d.center_x_q4     = cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y:     cfg_d.center_y_q4     = cfg_data_i[CENTER_W-1:0];
        REG_INV_FOCAL_X:  cfg_d.inv_focal_x_q24 = cfg_data_i[RECIP_W-1:0];
        REG_INV_FOCAL_Y:  cfg_d.inv_focal_y_q24 = cfg_data_i[RECIP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= RST_FRAME_WIDTH;
      cfg_q.frame_height    <= RST_FRAME_HEIGHT;
      cfg_q.center_x_q4     <= RST_CENTER_X;
      cfg_q.center_y_q4     <= RST_CENTER_Y;
      cfg_q.inv_focal_x_q24 <= RST_INV_FOCAL_X;
      cfg_q.inv_focal_y_q24 <= RST_INV_FOCAL_Y;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dpb_front #(
    .MaxFrameDim (MaxFrameDim)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .depth_mm_i    (depth_mm_i),
    .frame_start_i (frame_start_i),
    .full_o        (full),
    .mid_full_i    (mid_full),
    .mid_push_o    (mid_push),
    .mid_data_o    (mid_wdata)
  );

  dpb_fifo #(
    .Width (ItemW),
    .Depth (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o ()
  );

  dpb_back #(
    .MaxFrameDim (MaxFrameDim),
    .RecipFrac   (RecipFrac)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign point_x_q4_o  = result.point_x_q4;
  assign point_y_q4_o  = result.point_y_q4;
  assign point_z_mm_o  = result.point_z_mm;
  assign point_valid_o = result.point_valid;
  assign frame_end_o   = result.frame_end;

endmodule

FILE: design/dpb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_checker: port-level checks for depth pixel back-projection
// Watches the result queue and flags malformed points or unstable output.
// ----------------------------------------------------------------------------
module dpb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [dpb_pkg::XY_W-1:0]    point_x_q4_o,
  input logic [dpb_pkg::XY_W-1:0]    point_y_q4_o,
  input logic [dpb_pkg::DEPTH_W-1:0] point_z_mm_o,
  input logic                        point_valid_o,
  input logic                        frame_end_o
);

  // An end marker carries no coordinates and always closes a frame
  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !point_valid_o) |->
      (frame_end_o && point_x_q4_o == '0 && point_y_q4_o == '0 && point_z_mm_o == '0))
    else $error("end marker with nonzero payload or no frame end");

  // A real point always has nonzero depth
  a_point_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && point_valid_o) |-> (point_z_mm_o != '0))
    else $error("point with zero depth");

  // Hold the waiting item until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(point_x_q4_o) && $stable(point_y_q4_o) &&
       $stable(point_z_mm_o) && $stable(point_valid_o) && $stable(frame_end_o)))
    else $error("waiting item changed or vanished");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .point_x_q4_o  (point_x_q4_o),
  .point_y_q4_o  (point_y_q4_o),
  .point_z_mm_o  (point_z_mm_o),
  .point_valid_o (point_valid_o),
  .frame_end_o   (frame_end_o)
);
